// File: hdl/rsc_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte step for the record
// sync and CRC checker. No dependencies.
package rsc_pkg;

  localparam int BYTE_W     = 8;
  localparam int OFFSET_W   = 11;
  localparam int CRC_W      = 16;
  localparam int CELL_CFG_W = 10;

  // Record layout: four tags, then the little-endian CRC field.
  localparam int SYNC_LEN   = 4;
  localparam int CRC_LO_OFF = 4;
  localparam int CRC_HI_OFF = 5;
  localparam int BASE_LEN   = 36;

  localparam logic [BYTE_W-1:0] TAG_CHARGE    = 8'hFC;
  localparam logic [BYTE_W-1:0] TAG_DISCHARGE = 8'hFD;
  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  // CRC after the four tag bytes, per record kind.
  localparam logic [CRC_W-1:0] CRC_TAGS_CHARGE =
    crc16_byte(crc16_byte(crc16_byte(crc16_byte(16'h0000, TAG_CHARGE),
      TAG_CHARGE), TAG_CHARGE), TAG_CHARGE);
  localparam logic [CRC_W-1:0] CRC_TAGS_DISCHARGE =
    crc16_byte(crc16_byte(crc16_byte(crc16_byte(16'h0000, TAG_DISCHARGE),
      TAG_DISCHARGE), TAG_DISCHARGE), TAG_DISCHARGE);

  typedef struct packed {
    logic found;  // this byte completes four equal tags
    logic kind;   // 0 charge, 1 discharge
  } hunt_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [BYTE_W-1:0]   record_byte;
    logic                last_byte;
    logic                record_kind;
    logic                status;
    logic [CRC_W-1:0]    computed_crc;
    logic [CRC_W-1:0]    received_crc;
  } rec_res_t;

endpackage

// File: hdl/rsc_hunt.sv
// Sync hunter: sliding window over the last three hunted bytes.
// Depends on rsc_pkg.
module rsc_hunt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [rsc_pkg::BYTE_W-1:0] data,
  output rsc_pkg::hunt_t            hunt
);
  import rsc_pkg::*;

  localparam int WIN = SYNC_LEN - 1;

  logic [WIN-1:0][BYTE_W-1:0] win_r, win_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       all_eq;
  logic                       is_tag;

  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      if (win_r[i] != data) begin
        all_eq = 1'b0;
      end
    end
    is_tag     = (data == TAG_CHARGE) || (data == TAG_DISCHARGE);
    hunt.found = (cnt_r == 2'(WIN)) && all_eq && is_tag;
    hunt.kind  = (data == TAG_DISCHARGE);
  end

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (step) begin
      if (hunt.found) begin
        // empty the window at record start
        win_nxt = '0;
        cnt_nxt = '0;
      end else begin
        win_nxt = {win_r[WIN-2:0], data};
        if (cnt_r != 2'(WIN)) begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
    end else begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/rsc_rec.sv
// Record tracker: offset counter, running CRC, stored CRC field and the
// result item for each record byte. Depends on rsc_pkg.
module rsc_rec #(
  parameter int MAX_CELLS = 512,
  parameter int CELLS_W   = 10,
  parameter int POS_W     = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [rsc_pkg::BYTE_W-1:0]    data,
  input  rsc_pkg::hunt_t                hunt,
  input  logic [rsc_pkg::CELL_CFG_W-1:0] cell_count,
  output logic                          active,
  output rsc_pkg::rec_res_t             res
);
  import rsc_pkg::*;

  logic                 active_r, active_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [CRC_W-1:0]     crc_r, crc_nxt;
  logic [CRC_W-1:0]     stored_r, stored_nxt;
  logic                 kind_r, kind_nxt;

  logic [CELLS_W-1:0]   cells;
  logic [POS_W-1:0]     last_off;
  logic [CRC_W-1:0]     crc_step;
  logic [CRC_W-1:0]     stored_upd;
  logic                 in_crc_field;
  logic                 last;

  assign active = active_r;

  always_comb begin
    if ({1'b0, cell_count} > 11'(MAX_CELLS)) begin
      cells = CELLS_W'(MAX_CELLS);
    end else begin
      cells = CELLS_W'(cell_count);
    end
    last_off = POS_W'(BASE_LEN - 1) + (POS_W'(cells) << 1);

    stored_upd = stored_r;
    if (pos_r == POS_W'(CRC_LO_OFF)) begin
      stored_upd = {8'h00, data};
    end else if (pos_r == POS_W'(CRC_HI_OFF)) begin
      stored_upd = {data, stored_r[7:0]};
    end
    // the CRC field counts as zero
    in_crc_field = (pos_r == POS_W'(CRC_LO_OFF)) || (pos_r == POS_W'(CRC_HI_OFF));
    crc_step     = crc16_byte(crc_r, in_crc_field ? '0 : data);
    last         = (pos_r >= last_off);

    res.byte_offset  = OFFSET_W'(pos_r);
    res.record_byte  = data;
    res.last_byte    = last;
    res.record_kind  = kind_r;
    res.status       = last && (crc_step != stored_upd);
    res.computed_crc = last ? crc_step : '0;
    res.received_crc = stored_upd;
  end

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    stored_nxt = stored_r;
    kind_nxt   = kind_r;
    if (fire) begin
      if (!active_r) begin
        if (hunt.found) begin
          active_nxt = 1'b1;
          pos_nxt    = POS_W'(SYNC_LEN);
          crc_nxt    = hunt.kind ? CRC_TAGS_DISCHARGE : CRC_TAGS_CHARGE;
          stored_nxt = '0;
          kind_nxt   = hunt.kind;
        end
      end else begin
        stored_nxt = stored_upd;
        if (last) begin
          // drop back to hunting
          active_nxt = 1'b0;
          pos_nxt    = '0;
          crc_nxt    = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
          crc_nxt = crc_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
      crc_r    <= '0;
      stored_r <= '0;
      kind_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      stored_r <= stored_nxt;
      kind_r   <= kind_nxt;
    end
  end

endmodule

// File: hdl/record_sync_crc_checker_top.sv
// Top level of the record sync and CRC checker: input register, cell count
// register, output register. Depends on rsc_pkg, rsc_hunt, rsc_rec.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_stream_byte
//   out_    | output    | out_valid/out_stall | byte_offset .. received_crc
//   cfg_    | input     | cfg_wr_en           | cfg_wr_data (cell count)
//
// One byte per cycle sustained while out_stall is low; an accepted
// transaction goes through the input register, then one pass through the
// sync window and one CRC byte step into the output register, to out_valid.
// Bytes while hunting produce no output transaction.
// out_stall holds the output register; the input register still drains
// hunted bytes, and in_stall rises only when a record byte meets a full one.
// rst_n is synchronous; it clears the window, record state and valid flags.
module record_sync_crc_checker_top #(
  parameter int MAX_CELLS = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rsc_pkg::BYTE_W-1:0]     in_stream_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rsc_pkg::OFFSET_W-1:0]   out_byte_offset,
  output logic [rsc_pkg::BYTE_W-1:0]     out_record_byte,
  output logic                           out_last_byte,
  output logic                           out_record_kind,
  output logic                           out_status,
  output logic [rsc_pkg::CRC_W-1:0]      out_computed_crc,
  output logic [rsc_pkg::CRC_W-1:0]      out_received_crc,
  input  logic                           cfg_wr_en,
  input  logic [rsc_pkg::CELL_CFG_W-1:0] cfg_wr_data
);
  import rsc_pkg::*;

  localparam int CELLS_W = $clog2(MAX_CELLS + 1);
  localparam int POS_W   = $clog2(BASE_LEN + 2 * MAX_CELLS);

  logic [CELL_CFG_W-1:0] cells_r;
  logic                  in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0]     in_byte_r;
  logic                  out_vld_r, out_vld_nxt;
  rec_res_t              out_r;

  logic                  accept;
  logic                  fire;
  logic                  rec_active;
  hunt_t                 hunt;
  rec_res_t              res;

  // A hunted byte never needs the output slot.
  assign fire     = in_vld_r && (!rec_active || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign accept   = in_valid && !in_stall;

  rsc_hunt u_hunt (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (fire && !rec_active),
    .data  (in_byte_r),
    .hunt  (hunt)
  );

  rsc_rec #(
    .MAX_CELLS (MAX_CELLS),
    .CELLS_W   (CELLS_W),
    .POS_W     (POS_W)
  ) u_rec (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data       (in_byte_r),
    .hunt       (hunt),
    .cell_count (cells_r),
    .active     (rec_active),
    .res        (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire && rec_active) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r   <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cells_r <= cfg_wr_data;
      end
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_stream_byte;
    end
    if (fire && rec_active) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte_offset  = out_r.byte_offset;
  assign out_record_byte  = out_r.record_byte;
  assign out_last_byte    = out_r.last_byte;
  assign out_record_kind  = out_r.record_kind;
  assign out_status       = out_r.status;
  assign out_computed_crc = out_r.computed_crc;
  assign out_received_crc = out_r.received_crc;

endmodule

// File: hdl/rsc_checker.sv
// Port-level checks for record_sync_crc_checker_top, bound to the top level.
// Depends on rsc_pkg.
module rsc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rsc_pkg::OFFSET_W-1:0]   out_byte_offset,
  input logic [rsc_pkg::BYTE_W-1:0]     out_record_byte,
  input logic                           out_last_byte,
  input logic                           out_status,
  input logic [rsc_pkg::CRC_W-1:0]      out_computed_crc,
  input logic [rsc_pkg::CRC_W-1:0]      out_received_crc
);
  import rsc_pkg::*;

  // Status and computed CRC only on the last byte.
  a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |-> !out_status && (out_computed_crc == '0))
    else $error("status or CRC set on a non-final byte");

  a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_status == (out_computed_crc != out_received_crc))
    else $error("status disagrees with CRC compare");

  a_crc_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_offset == OFFSET_W'(CRC_LO_OFF)) |->
      out_received_crc == {8'h00, out_record_byte})
    else $error("received CRC low byte mismatch");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_record_byte)
      && $stable(out_byte_offset))
    else $error("stalled transaction changed");

endmodule

bind record_sync_crc_checker_top rsc_checker u_rsc_checker (.*);
